// ===== hw/rtl/lsi3d_pkg.sv =====
package lsi3d_pkg;

    localparam int TOL_W = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

    localparam int CRD_W = 32;   // coordinate width, Q16.16
    localparam int VEC_W = 33;   // a, b, c components
    localparam int PRD_W = 66;   // product of two vector components
    localparam int CRS_W = 67;   // cross product component
    localparam int TRP_W = 102;  // triple product
    localparam int BIG_W = 136;  // numerator and denominator
    localparam int REM_W = 137;  // divider remainder after the shift
    localparam int PAR_W = 17;   // parameter t, Q1.16, at most 1.0
    localparam int PNT_W = 51;   // t times a component

    typedef struct packed {
        logic signed [CRD_W-1:0] seg0_start_x;
        logic signed [CRD_W-1:0] seg0_start_y;
        logic signed [CRD_W-1:0] seg0_start_z;
        logic signed [CRD_W-1:0] seg0_end_x;
        logic signed [CRD_W-1:0] seg0_end_y;
        logic signed [CRD_W-1:0] seg0_end_z;
        logic signed [CRD_W-1:0] seg1_start_x;
        logic signed [CRD_W-1:0] seg1_start_y;
        logic signed [CRD_W-1:0] seg1_start_z;
        logic signed [CRD_W-1:0] seg1_end_x;
        logic signed [CRD_W-1:0] seg1_end_y;
        logic signed [CRD_W-1:0] seg1_end_z;
    } lsi3d_query_t;

    typedef struct packed {
        logic                    hit;
        logic signed [CRD_W-1:0] point_x;
        logic signed [CRD_W-1:0] point_y;
        logic signed [CRD_W-1:0] point_z;
        logic [PAR_W-1:0]        param_t;
    } lsi3d_result_t;

endpackage

// ===== hw/rtl/line_segment_intersection_3d.sv =====
// 3D segment intersection pipeline.
// A query word is taken at each rising edge where start is high and busy is
// low. busy is always low, so a new query may be issued in every cycle.
// Each query produces exactly one result word: done is high for one cycle
// with result valid in that same cycle.
// Throughput is one query per cycle; the pipeline is made of seven stages that
// form the differences, the cross and dot products (wide products split into
// 32-bit partials) and the hit test, a 17-stage restoring divider producing
// one bit of t per stage, and two stages that form and saturate the point.
// The receiver cannot hold results off; none is needed since the pipe never
// stalls.
// The coplanar tolerance is written through cfg_valid/cfg_data, which is
// always ready; write it only while no query is in flight.
// Reset clears all stage valid bits, so no result appears until a query
// has gone through, and returns the tolerance to its default.
// A miss (not coplanar, parallel, or t outside 0..1) returns hit low and
// all other fields zero.
module line_segment_intersection_3d (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lsi3d_pkg::lsi3d_query_t      query,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lsi3d_pkg::TOL_W-1:0]  cfg_data,
    output logic                         done,
    output lsi3d_pkg::lsi3d_result_t     result
);
    import lsi3d_pkg::*;

    logic [TOL_W-1:0] tol_reg;

    // Stage 1: difference vectors.
    logic                    v1_reg;
    logic signed [VEC_W-1:0] a1_reg [3];
    logic signed [VEC_W-1:0] b1_reg [3];
    logic signed [VEC_W-1:0] c1_reg [3];
    logic signed [CRD_W-1:0] s01_reg [3];
    logic signed [CRD_W-1:0] p0_in [3];
    logic signed [CRD_W-1:0] p1_in [3];
    logic signed [CRD_W-1:0] q0_in [3];
    logic signed [CRD_W-1:0] q1_in [3];

    // Stage 2: cross product terms.
    logic                    v2_reg;
    logic signed [PRD_W-1:0] abp2_reg [3];
    logic signed [PRD_W-1:0] abm2_reg [3];
    logic signed [PRD_W-1:0] cbp2_reg [3];
    logic signed [PRD_W-1:0] cbm2_reg [3];
    logic signed [VEC_W-1:0] a2_reg [3];
    logic signed [VEC_W-1:0] c2_reg [3];
    logic signed [CRD_W-1:0] s02_reg [3];

    // Stage 3: cross products.
    logic                    v3_reg;
    logic signed [CRS_W-1:0] axb3_reg [3];
    logic signed [CRS_W-1:0] cxb3_reg [3];
    logic signed [VEC_W-1:0] a3_reg [3];
    logic signed [VEC_W-1:0] c3_reg [3];
    logic signed [CRD_W-1:0] s03_reg [3];

    // Stage 4: partial products of the dot products.
    logic                    v4_reg;
    logic signed [67:0]      uh4_reg [3];
    logic signed [65:0]      ul4_reg [3];
    logic signed [69:0]      dhh4_reg [3];
    logic signed [67:0]      dhl4_reg [3];
    logic signed [65:0]      dll4_reg [3];
    logic signed [69:0]      nhh4_reg [3];
    logic signed [67:0]      nhl4_reg [3];
    logic signed [67:0]      nlh4_reg [3];
    logic signed [65:0]      nll4_reg [3];
    logic signed [VEC_W-1:0] a4_reg [3];
    logic signed [CRD_W-1:0] s04_reg [3];

    // Stage 5: per-component products.
    logic                    v5_reg;
    logic signed [TRP_W-1:0] u5_reg [3];
    logic signed [BIG_W-1:0] d5_reg [3];
    logic signed [BIG_W-1:0] n5_reg [3];
    logic signed [VEC_W-1:0] a5_reg [3];
    logic signed [CRD_W-1:0] s05_reg [3];

    // Stage 6: dot product sums.
    logic                    v6_reg;
    logic signed [TRP_W-1:0] u6_reg;
    logic signed [BIG_W-1:0] d6_reg;
    logic signed [BIG_W-1:0] n6_reg;
    logic signed [VEC_W-1:0] a6_reg [3];
    logic signed [CRD_W-1:0] s06_reg [3];

    // Stage 7: hit decision and divider operands.
    logic                    v7_reg;
    logic                    go7_reg;
    logic [REM_W-1:0]        rem7_reg;
    logic [REM_W-1:0]        den7_reg;
    logic signed [VEC_W-1:0] a7_reg [3];
    logic signed [CRD_W-1:0] s07_reg [3];
    logic [TRP_W-1:0]        u_abs;
    logic [TRP_W-1:0]        tol_wide;
    logic                    go7_next;

    // Divider stages.
    logic                    dv_v_reg [PAR_W];
    logic                    dv_go_reg [PAR_W];
    logic [REM_W-1:0]        dv_rem_reg [PAR_W];
    logic [REM_W-1:0]        dv_den_reg [PAR_W];
    logic [PAR_W-1:0]        dv_q_reg [PAR_W];
    logic signed [VEC_W-1:0] dv_a_reg [PAR_W][3];
    logic signed [CRD_W-1:0] dv_s0_reg [PAR_W][3];

    // Point stages.
    logic                    vp_reg;
    logic                    gop_reg;
    logic [PAR_W-1:0]        tp_reg;
    logic signed [PNT_W-1:0] prod_reg [3];
    logic signed [CRD_W-1:0] s0p_reg [3];

    logic                    done_reg;
    lsi3d_result_t           result_reg;
    lsi3d_result_t           result_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    assign p0_in[0] = query.seg0_start_x;
    assign p0_in[1] = query.seg0_start_y;
    assign p0_in[2] = query.seg0_start_z;
    assign p1_in[0] = query.seg0_end_x;
    assign p1_in[1] = query.seg0_end_y;
    assign p1_in[2] = query.seg0_end_z;
    assign q0_in[0] = query.seg1_start_x;
    assign q0_in[1] = query.seg1_start_y;
    assign q0_in[2] = query.seg1_start_z;
    assign q1_in[0] = query.seg1_end_x;
    assign q1_in[1] = query.seg1_end_y;
    assign q1_in[2] = query.seg1_end_z;

    // Valid bits for the fixed stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            vp_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            vp_reg <= dv_v_reg[PAR_W-1];
            done_reg <= vp_reg;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_comp
        localparam int I = (k + 1) % 3;
        localparam int J = (k + 2) % 3;

        logic signed [34:0] axh;
        logic signed [32:0] axl;
        logic signed [34:0] cxh;
        logic signed [32:0] cxl;

        assign axh = signed'(axb3_reg[k][CRS_W-1:32]);
        assign axl = signed'({1'b0, axb3_reg[k][31:0]});
        assign cxh = signed'(cxb3_reg[k][CRS_W-1:32]);
        assign cxl = signed'({1'b0, cxb3_reg[k][31:0]});

        always_ff @(posedge clk)
        begin
            a1_reg[k]  <= VEC_W'(p1_in[k]) - VEC_W'(p0_in[k]);
            b1_reg[k]  <= VEC_W'(q1_in[k]) - VEC_W'(q0_in[k]);
            c1_reg[k]  <= VEC_W'(q0_in[k]) - VEC_W'(p0_in[k]);
            s01_reg[k] <= p0_in[k];

            abp2_reg[k] <= PRD_W'(a1_reg[I]) * PRD_W'(b1_reg[J]);
            abm2_reg[k] <= PRD_W'(a1_reg[J]) * PRD_W'(b1_reg[I]);
            cbp2_reg[k] <= PRD_W'(c1_reg[I]) * PRD_W'(b1_reg[J]);
            cbm2_reg[k] <= PRD_W'(c1_reg[J]) * PRD_W'(b1_reg[I]);
            a2_reg[k]   <= a1_reg[k];
            c2_reg[k]   <= c1_reg[k];
            s02_reg[k]  <= s01_reg[k];

            axb3_reg[k] <= CRS_W'(abp2_reg[k]) - CRS_W'(abm2_reg[k]);
            cxb3_reg[k] <= CRS_W'(cbp2_reg[k]) - CRS_W'(cbm2_reg[k]);
            a3_reg[k]   <= a2_reg[k];
            c3_reg[k]   <= c2_reg[k];
            s03_reg[k]  <= s02_reg[k];

            // Wide operands are split into a signed high part and an unsigned
            // low word, so each multiplier stays near 32 by 32 bits.
            uh4_reg[k]  <= 68'(c3_reg[k]) * 68'(axh);
            ul4_reg[k]  <= 66'(c3_reg[k]) * 66'(axl);
            dhh4_reg[k] <= 70'(axh) * 70'(axh);
            dhl4_reg[k] <= 68'(axh) * 68'(axl);
            dll4_reg[k] <= 66'(axl) * 66'(axl);
            nhh4_reg[k] <= 70'(cxh) * 70'(axh);
            nhl4_reg[k] <= 68'(cxh) * 68'(axl);
            nlh4_reg[k] <= 68'(cxl) * 68'(axh);
            nll4_reg[k] <= 66'(cxl) * 66'(axl);
            a4_reg[k]   <= a3_reg[k];
            s04_reg[k]  <= s03_reg[k];

            u5_reg[k] <= (TRP_W'(uh4_reg[k]) <<< 32) + TRP_W'(ul4_reg[k]);
            d5_reg[k] <= (BIG_W'(dhh4_reg[k]) <<< 64) + (BIG_W'(dhl4_reg[k]) <<< 33)
                         + BIG_W'(dll4_reg[k]);
            n5_reg[k] <= (BIG_W'(nhh4_reg[k]) <<< 64)
                         + ((BIG_W'(nhl4_reg[k]) + BIG_W'(nlh4_reg[k])) <<< 32)
                         + BIG_W'(nll4_reg[k]);
            a5_reg[k]  <= a4_reg[k];
            s05_reg[k] <= s04_reg[k];

            a6_reg[k]  <= a5_reg[k];
            s06_reg[k] <= s05_reg[k];
            a7_reg[k]  <= a6_reg[k];
            s07_reg[k] <= s06_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        u6_reg <= u5_reg[0] + u5_reg[1] + u5_reg[2];
        d6_reg <= d5_reg[0] + d5_reg[1] + d5_reg[2];
        n6_reg <= n5_reg[0] + n5_reg[1] + n5_reg[2];
    end

    always_comb
    begin
        u_abs    = u6_reg[TRP_W-1] ? TRP_W'(-u6_reg) : TRP_W'(u6_reg);
        tol_wide = {{(TRP_W - TOL_W - 32){1'b0}}, tol_reg, 32'd0};
        // Coplanar, not parallel, and 0 <= num <= den.
        go7_next = (u_abs <= tol_wide) && (d6_reg != '0) && !n6_reg[BIG_W-1]
                   && (n6_reg <= d6_reg);
    end

    always_ff @(posedge clk)
    begin
        go7_reg  <= go7_next;
        rem7_reg <= REM_W'(unsigned'(n6_reg));
        den7_reg <= REM_W'(unsigned'(d6_reg));
    end

    // Restoring divider, one quotient bit per stage; the first stage does
    // not shift, so a quotient of exactly 1.0 comes out as 65536.
    for (genvar g = 0; g < PAR_W; g++)
    begin : g_div
        logic                    v_in;
        logic                    go_in;
        logic [REM_W-1:0]        rem_in;
        logic [REM_W-1:0]        den_in;
        logic [PAR_W-1:0]        q_in;
        logic signed [VEC_W-1:0] a_in [3];
        logic signed [CRD_W-1:0] s0_in [3];
        logic [REM_W-1:0]        sh;
        logic                    qbit;

        if (g == 0)
        begin : g_first
            assign v_in   = v7_reg;
            assign go_in  = go7_reg;
            assign rem_in = rem7_reg;
            assign den_in = den7_reg;
            assign q_in   = '0;
            assign sh     = rem_in;
            for (genvar k = 0; k < 3; k++)
            begin : g_c
                assign a_in[k]  = a7_reg[k];
                assign s0_in[k] = s07_reg[k];
            end
        end
        else
        begin : g_next
            assign v_in   = dv_v_reg[g-1];
            assign go_in  = dv_go_reg[g-1];
            assign rem_in = dv_rem_reg[g-1];
            assign den_in = dv_den_reg[g-1];
            assign q_in   = dv_q_reg[g-1];
            assign sh     = {rem_in[REM_W-2:0], 1'b0};
            for (genvar k = 0; k < 3; k++)
            begin : g_c
                assign a_in[k]  = dv_a_reg[g-1][k];
                assign s0_in[k] = dv_s0_reg[g-1][k];
            end
        end

        assign qbit = (sh >= den_in);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[g] <= 1'b0;
            end
            else
            begin
                dv_v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_go_reg[g]  <= go_in;
            dv_rem_reg[g] <= qbit ? (sh - den_in) : sh;
            dv_den_reg[g] <= den_in;
            dv_q_reg[g]   <= {q_in[PAR_W-2:0], qbit};
            for (int k = 0; k < 3; k++)
            begin
                dv_a_reg[g][k]  <= a_in[k];
                dv_s0_reg[g][k] <= s0_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gop_reg <= dv_go_reg[PAR_W-1];
        tp_reg  <= dv_q_reg[PAR_W-1];
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= PNT_W'(signed'({1'b0, dv_q_reg[PAR_W-1]}))
                           * PNT_W'(dv_a_reg[PAR_W-1][k]);
            s0p_reg[k]  <= dv_s0_reg[PAR_W-1][k];
        end
    end

    always_comb
    begin
        logic signed [CRD_W+3:0] pnt [3];
        logic signed [CRD_W-1:0] sat [3];
        for (int k = 0; k < 3; k++)
        begin
            // Arithmetic shift gives the floor of t * a / 65536.
            pnt[k] = (CRD_W+4)'(s0p_reg[k]) + (CRD_W+4)'(prod_reg[k] >>> 16);
            if (pnt[k] > (CRD_W+4)'(36'sh07FFFFFFF))
            begin
                sat[k] = 32'sh7FFFFFFF;
            end
            else if (pnt[k] < (CRD_W+4)'(-36'sh080000000))
            begin
                sat[k] = -32'sh80000000;
            end
            else
            begin
                sat[k] = CRD_W'(pnt[k]);
            end
        end
        result_next.hit     = gop_reg;
        result_next.point_x = gop_reg ? sat[0] : '0;
        result_next.point_y = gop_reg ? sat[1] : '0;
        result_next.point_z = gop_reg ? sat[2] : '0;
        result_next.param_t = gop_reg ? tp_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule
